[hw/rtl/aegu_pkg.sv]
// shared types, codes and helpers for the exponent group unpacker
package aegu_pkg;

  localparam int QueueDepth = 2;
  localparam logic [6:0] MaxCode = 7'd124;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_GROUP = 1'b1;

  localparam logic [1:0] STRAT_REUSE = 2'd0;
  localparam logic [1:0] STRAT_D15   = 2'd1;
  localparam logic [1:0] STRAT_D25   = 2'd2;
  localparam logic [1:0] STRAT_D45   = 2'd3;

  typedef struct packed {
    logic       single;
    logic       err;
    logic [1:0] rep_max;
    logic [7:0] e0;
    logic [7:0] e1;
    logic [7:0] e2;
  } job_t;

  typedef struct packed {
    logic [2:0] d0;
    logic [2:0] d1;
    logic [2:0] d2;
  } digits_t;

  // base-5 split of a group code by compare and select
  function automatic digits_t split_code(input logic [6:0] code);
    digits_t    r;
    logic [6:0] rem25;
    logic [4:0] rem5;
    if (code >= 7'd100) begin
      r.d0 = 3'd4;
    end else if (code >= 7'd75) begin
      r.d0 = 3'd3;
    end else if (code >= 7'd50) begin
      r.d0 = 3'd2;
    end else if (code >= 7'd25) begin
      r.d0 = 3'd1;
    end else begin
      r.d0 = 3'd0;
    end
    rem25 = code - 7'(r.d0 * 7'd25);
    if (rem25 >= 7'd20) begin
      r.d1 = 3'd4;
    end else if (rem25 >= 7'd15) begin
      r.d1 = 3'd3;
    end else if (rem25 >= 7'd10) begin
      r.d1 = 3'd2;
    end else if (rem25 >= 7'd5) begin
      r.d1 = 3'd1;
    end else begin
      r.d1 = 3'd0;
    end
    rem5 = rem25[4:0] - 5'(r.d1 * 5'd5);
    r.d2 = rem5[2:0];
    return r;
  endfunction

endpackage

[hw/rtl/aegu_front.sv]
// front end: channel state, group code decode and job building
module aegu_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic                command,
  input  logic [1:0]          strategy,
  input  logic                is_coupling,
  input  logic [6:0]          value,
  input  logic                last_group,
  output logic                enq,
  output aegu_pkg::job_t      job
);

  logic [7:0] accumulator, accumulator_next;
  logic [1:0] current_strategy, current_strategy_next;
  logic       channel_active, channel_active_next;

  aegu_pkg::digits_t dig;
  logic [7:0] e0, e1, e2;

  assign dig = aegu_pkg::split_code(value);
  assign e0 = accumulator + {5'd0, dig.d0} - 8'd2;
  assign e1 = e0 + {5'd0, dig.d1} - 8'd2;
  assign e2 = e1 + {5'd0, dig.d2} - 8'd2;

  always_comb begin
    accumulator_next = accumulator;
    current_strategy_next = current_strategy;
    channel_active_next = channel_active;
    enq = 1'b0;
    job.single = 1'b1;
    job.err = 1'b0;
    job.rep_max = 2'd0;
    job.e0 = {1'b0, value};
    job.e1 = e1;
    job.e2 = e2;
    if (command == aegu_pkg::CMD_START) begin
      accumulator_next = {1'b0, value};
      current_strategy_next = strategy;
      channel_active_next = (strategy != aegu_pkg::STRAT_REUSE) && !last_group;
      enq = accept && (strategy != aegu_pkg::STRAT_REUSE) && !is_coupling;
    end else if (channel_active) begin
      if (value > aegu_pkg::MaxCode) begin
        channel_active_next = 1'b0;
        enq = accept;
        job.err = 1'b1;
        job.e0 = 8'd0;
      end else begin
        accumulator_next = e2;
        channel_active_next = !last_group;
        enq = accept;
        job.single = 1'b0;
        job.e0 = e0;
        case (current_strategy)
          aegu_pkg::STRAT_D25: job.rep_max = 2'd1;
          aegu_pkg::STRAT_D45: job.rep_max = 2'd3;
          default:             job.rep_max = 2'd0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator <= 8'd0;
      current_strategy <= aegu_pkg::STRAT_REUSE;
      channel_active <= 1'b0;
    end else if (accept) begin
      accumulator <= accumulator_next;
      current_strategy <= current_strategy_next;
      channel_active <= channel_active_next;
    end
  end

endmodule

[hw/rtl/aegu_queue.sv]
// short job queue between front and back
module aegu_queue #(
  parameter int Depth = aegu_pkg::QueueDepth
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  aegu_pkg::job_t wr_data,
  input  logic           rd_en,
  output aegu_pkg::job_t rd_data,
  output logic           full,
  output logic           nonempty
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  aegu_pkg::job_t mem [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  assign full = (count == CntW'(Depth));
  assign nonempty = (count != '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + CntW'(1);
        2'b01:   count <= count - CntW'(1);
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTH
  a_no_write_when_full: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && full && !rd_en)) else $error("queue written while full");
  a_no_read_when_empty: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> nonempty) else $error("queue read while empty");
`endif

endmodule

[hw/rtl/aegu_back.sv]
// back end: expands jobs into result words through an output register
module aegu_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  input  aegu_pkg::job_t     job,
  output logic               deq,
  input  logic               pop,
  output logic               empty,
  output logic signed [7:0]  exponent,
  output logic               last,
  output logic               error
);

  logic       out_valid;
  logic       advance;
  logic [1:0] digit, digit_next;
  logic [1:0] rep, rep_next;
  logic [7:0] sel_exp;
  logic       sel_last;

  assign advance = !out_valid || pop;
  assign empty = !out_valid;

  always_comb begin
    digit_next = digit;
    rep_next = rep;
    deq = 1'b0;
    sel_last = 1'b1;
    case (digit)
      2'd0:    sel_exp = job.e0;
      2'd1:    sel_exp = job.e1;
      default: sel_exp = job.e2;
    endcase
    if (job.single) begin
      deq = advance && job_valid;
    end else begin
      sel_last = (digit == 2'd2) && (rep == job.rep_max);
      if (advance && job_valid) begin
        if (rep == job.rep_max) begin
          rep_next = 2'd0;
          if (digit == 2'd2) begin
            digit_next = 2'd0;
            deq = 1'b1;
          end else begin
            digit_next = digit + 2'd1;
          end
        end else begin
          rep_next = rep + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      digit <= 2'd0;
      rep <= 2'd0;
    end else begin
      digit <= digit_next;
      rep <= rep_next;
      if (advance) begin
        out_valid <= job_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && job_valid) begin
      exponent <= $signed(sel_exp);
      last <= sel_last;
      error <= job.err;
    end
  end

`ifndef SYNTH
  a_idle_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid) else $error("result word visible after reset");
  a_counters_clear_on_dequeue: assert property (@(posedge clk) disable iff (rst)
    deq |=> (digit == 2'd0) && (rep == 2'd0)) else $error("counters left set");
`endif

endmodule

[hw/rtl/ac3_exponent_group_unpacker_unit.sv]
// top level of the exponent group unpacker
// usage:
//   input words go in through push/full: a start word (command 0) opens a
//   channel with its strategy and initial exponent, group words (command 1)
//   carry one 0..124 code each. a word is taken when push is high and full
//   is low.
//   result words come out through empty/pop: the oldest word sits on
//   exponent/last/error while empty is low and leaves when pop is high.
//   last marks the final result word caused by one input word; error marks
//   a bad group code, after which the channel's remaining groups are dropped.
// timing:
//   the front decodes a word in the cycle it is taken and queues at most
//   one job, which passes through the queue and the output register. the
//   back emits one word per cycle while the receiver pops and a job waits; a
//   group yields 3, 6 or 12 words for D15, D25 or D45, a start at most 1, and
//   that emit loop sets the sustained rate. the queue holds aegu_pkg::QueueDepth
//   jobs, so the front takes words in a receiver stall until full rises.
// reset: synchronous, clears the channel state, the queue and the output.
module ac3_exponent_group_unpacker_unit #(
  parameter int QueueDepth = aegu_pkg::QueueDepth
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic              command,
  input  logic [1:0]        strategy,
  input  logic              is_coupling,
  input  logic [6:0]        value,
  input  logic              last_group,
  output logic              empty,
  input  logic              pop,
  output logic signed [7:0] exponent,
  output logic              last,
  output logic              error
);

  logic           accept;
  logic           enq;
  logic           deq;
  logic           q_nonempty;
  aegu_pkg::job_t new_job;
  aegu_pkg::job_t head_job;

  assign accept = push && !full;

  aegu_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .command     (command),
    .strategy    (strategy),
    .is_coupling (is_coupling),
    .value       (value),
    .last_group  (last_group),
    .enq         (enq),
    .job         (new_job)
  );

  aegu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (enq),
    .wr_data  (new_job),
    .rd_en    (deq),
    .rd_data  (head_job),
    .full     (full),
    .nonempty (q_nonempty)
  );

  aegu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_nonempty),
    .job       (head_job),
    .deq       (deq),
    .pop       (pop),
    .empty     (empty),
    .exponent  (exponent),
    .last      (last),
    .error     (error)
  );

endmodule

[verif/ac3_exponent_group_unpacker_unit_tb.sv]
// self-checking testbench for the ac3 exponent group unpacker
`timescale 1ns / 1ps

module ac3_exponent_group_unpacker_unit_tb;

  localparam int CycleLimit = 300000;
  localparam int DrainCycles = 16;

  typedef struct packed {
    logic signed [7:0] exponent;
    logic              last;
    logic              error;
  } exp_word_t;

  logic              clk;
  logic              rst;
  logic              push;
  logic              full;
  logic              command;
  logic [1:0]        strategy;
  logic              is_coupling;
  logic [6:0]        value;
  logic              last_group;
  logic              empty;
  logic              pop;
  logic signed [7:0] exponent;
  logic              last;
  logic              error;

  // decoder state as the testbench tracks it
  logic [7:0] running_exp;
  logic [1:0] chan_strategy;
  bit         chan_open;

  exp_word_t  expected_exps[$];
  exp_word_t  want;

  bit send_gaps;
  bit pop_gaps;
  int hold_request;
  int fail_count;
  int cycle_count;
  int words_decoded;
  int starts_sent;
  int groups_sent;
  int bad_codes_sent;
  int words_checked;

  ac3_exponent_group_unpacker_unit uut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .command    (command),
    .strategy   (strategy),
    .is_coupling(is_coupling),
    .value      (value),
    .last_group (last_group),
    .empty      (empty),
    .pop        (pop),
    .exponent   (exponent),
    .last       (last),
    .error      (error)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // mostly no gap, some short ones, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // updates the tracked state for one word and queues the exponents it yields;
  // returns 0 when the block just drops the word
  function automatic bit decode_exponents(input logic cmd, input logic [1:0] strat,
                                          input logic coup, input logic [6:0] code,
                                          input logic closes);
    int        digit[3];
    int        reps;
    exp_word_t w;
    if (cmd == aegu_pkg::CMD_START) begin
      running_exp   = {1'b0, code};
      chan_strategy = strat;
      if (strat == aegu_pkg::STRAT_REUSE) begin
        chan_open = 1'b0;
        return 1'b1;
      end
      chan_open = !closes;
      if (!coup) begin
        w = '{exponent: running_exp, last: 1'b1, error: 1'b0};
        expected_exps.push_back(w);
      end
      return 1'b1;
    end
    if (!chan_open) return 1'b0;
    if (code > aegu_pkg::MaxCode) begin
      chan_open = 1'b0;
      w = '{exponent: 8'sd0, last: 1'b1, error: 1'b1};
      expected_exps.push_back(w);
      return 1'b1;
    end
    digit[0] = code / 25;
    digit[1] = (code % 25) / 5;
    digit[2] = code % 5;
    reps = (chan_strategy == aegu_pkg::STRAT_D45) ? 4 :
           (chan_strategy == aegu_pkg::STRAT_D25) ? 2 : 1;
    for (int d = 0; d < 3; d++) begin
      running_exp = 8'(int'(running_exp) + digit[d] - 2);
      for (int r = 0; r < reps; r++) begin
        w = '{exponent: running_exp, last: (d == 2 && r == reps - 1), error: 1'b0};
        expected_exps.push_back(w);
      end
    end
    if (closes) chan_open = 1'b0;
    return 1'b1;
  endfunction

  task automatic send_word(input logic cmd, input logic [1:0] strat, input logic coup,
                           input logic [6:0] code, input logic closes);
    int gap;
    gap = send_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push        <= 1'b1;
    command     <= cmd;
    strategy    <= strat;
    is_coupling <= coup;
    value       <= code;
    last_group  <= closes;
    @(posedge clk);
    while (full) @(posedge clk);
    if (decode_exponents(cmd, strat, coup, code, closes)) words_decoded++;
    if (cmd == aegu_pkg::CMD_START) starts_sent++;
    else groups_sent++;
    if (cmd == aegu_pkg::CMD_GROUP && code > aegu_pkg::MaxCode) bad_codes_sent++;
  endtask

  task automatic send_group(input logic [6:0] code, input logic closes);
    send_word(aegu_pkg::CMD_GROUP, 2'($urandom), 1'($urandom), code, closes);
  endtask

  task automatic wait_drain();
    push <= 1'b0;
    while (expected_exps.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic test_channel_starts();
    send_word(aegu_pkg::CMD_START, aegu_pkg::STRAT_D15, 1'b0, 7'd0, 1'b0);
    send_word(aegu_pkg::CMD_START, aegu_pkg::STRAT_D45, 1'b1, 7'd127, 1'b1);
    send_word(aegu_pkg::CMD_START, aegu_pkg::STRAT_D25, 1'b0, 7'd127, 1'b1);
    send_word(aegu_pkg::CMD_START, aegu_pkg::STRAT_REUSE, 1'b0, 7'd55, 1'b0);
    // nothing open after reuse, so this group is dropped
    send_group(7'd0, 1'b0);
  endtask

  task automatic test_group_decoding();
    send_word(aegu_pkg::CMD_START, aegu_pkg::STRAT_D15, 1'b0, 7'd10, 1'b0);
    send_group(7'd0, 1'b0);
    send_group(7'd124, 1'b0);
    send_group(7'd62, 1'b1);
    // climbs past 127 into the negative range
    send_word(aegu_pkg::CMD_START, aegu_pkg::STRAT_D25, 1'b0, 7'd127, 1'b0);
    send_group(7'd124, 1'b1);
    // falls below zero and wraps
    send_word(aegu_pkg::CMD_START, aegu_pkg::STRAT_D45, 1'b1, 7'd0, 1'b0);
    send_group(7'd0, 1'b1);
  endtask

  task automatic test_bad_codes();
    send_word(aegu_pkg::CMD_START, aegu_pkg::STRAT_D25, 1'b0, 7'd40, 1'b0);
    send_group(7'd125, 1'b0);
    send_group(7'd30, 1'b0);
    send_word(aegu_pkg::CMD_START, aegu_pkg::STRAT_D15, 1'b1, 7'd90, 1'b0);
    send_group(7'd127, 1'b1);
  endtask

  task automatic test_abandoned_channel();
    send_word(aegu_pkg::CMD_START, aegu_pkg::STRAT_D45, 1'b0, 7'd20, 1'b0);
    send_group(7'd7, 1'b0);
    send_word(aegu_pkg::CMD_START, aegu_pkg::STRAT_D25, 1'b1, 7'd5, 1'b0);
    send_group(7'd99, 1'b1);
    send_group(7'd50, 1'b1);
  endtask

  // receiver stalls while the sender keeps pushing D45 groups, so full rises
  task automatic test_input_backpressure();
    hold_request = 80;
    send_gaps = 1'b0;
    send_word(aegu_pkg::CMD_START, aegu_pkg::STRAT_D45, 1'($urandom), 7'($urandom), 1'b0);
    for (int i = 0; i < 8; i++) send_group(7'($urandom_range(0, 124)), i == 7);
    send_gaps = 1'b1;
    wait_drain();
  endtask

  // mostly well-formed channels with random content, some stray and broken ones
  task automatic test_random_channels(input int goal);
    int stop_at;
    int r;
    int ngroups;
    logic [1:0] strat;
    logic [6:0] code;
    stop_at = words_decoded + goal;
    while (words_decoded < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        send_group(7'($urandom), 1'($urandom));
      end else begin
        strat = (r < 12) ? aegu_pkg::STRAT_REUSE : 2'($urandom_range(1, 3));
        send_word(aegu_pkg::CMD_START, strat, 1'($urandom), 7'($urandom),
                  $urandom_range(0, 15) == 0);
        ngroups = $urandom_range(1, 6);
        for (int i = 0; i < ngroups; i++) begin
          code = ($urandom_range(0, 19) == 0) ? 7'($urandom_range(125, 127))
                                              : 7'($urandom_range(0, 124));
          // now and then the channel is left open and the next start drops it
          send_group(code, (i == ngroups - 1) && ($urandom_range(0, 9) != 0));
        end
      end
    end
  endtask

  initial begin : pop_driver
    int idle;
    pop = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        idle = hold_request;
        hold_request = 0;
      end else if (!pop_gaps) begin
        idle = 0;
      end else begin
        idle = pick_gap();
      end
      if (idle == 0) begin
        pop <= 1'b1;
      end else begin
        pop <= 1'b0;
        repeat (idle - 1) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      words_checked++;
      if (expected_exps.size() == 0) begin
        $error("unexpected result word: exponent %0d last %0b error %0b",
               exponent, last, error);
        fail_count++;
      end else begin
        want = expected_exps.pop_front();
        if (exponent !== want.exponent) begin
          $error("exponent mismatch: expected %0d, got %0d", want.exponent, exponent);
          fail_count++;
        end
        if (last !== want.last) begin
          $error("last mismatch: expected %0b, got %0b", want.last, last);
          fail_count++;
        end
        if (error !== want.error) begin
          $error("error mismatch: expected %0b, got %0b", want.error, error);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d words still expected", cycle_count,
               expected_exps.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst          = 1'b1;
    push         = 1'b0;
    command      = aegu_pkg::CMD_START;
    strategy     = aegu_pkg::STRAT_REUSE;
    is_coupling  = 1'b0;
    value        = '0;
    last_group   = 1'b0;
    running_exp  = '0;
    chan_strategy = aegu_pkg::STRAT_REUSE;
    chan_open    = 1'b0;
    send_gaps    = 1'b1;
    pop_gaps     = 1'b1;
    hold_request = 0;
    fail_count   = 0;
    cycle_count  = 0;
    words_decoded = 0;
    starts_sent  = 0;
    groups_sent  = 0;
    bad_codes_sent = 0;
    words_checked = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_channel_starts();
    test_group_decoding();
    test_bad_codes();
    test_abandoned_channel();
    test_input_backpressure();
    test_random_channels(55);
    // a stretch with both sides running flat out
    send_gaps = 1'b0;
    pop_gaps  = 1'b0;
    test_random_channels(35);
    send_gaps = 1'b1;
    pop_gaps  = 1'b1;
    test_random_channels(40);
    push <= 1'b0;
    wait_drain();

    $display("sent %0d start words and %0d group words (%0d bad codes)",
             starts_sent, groups_sent, bad_codes_sent);
    $display("checked %0d result words, %0d mismatches", words_checked, fail_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
